// ===== hdl/pqrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pqrt_pkg: shared types and constants of the playlist queue / recent table
// Payload structs, command and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pqrt_pkg;

	localparam int CATALOG_ENTRIES_DEF = 32;
	localparam int KEY_WIDTH_DEF       = 32;

	localparam int QT_W    = 21;
	localparam logic [QT_W-1:0] QT_MAX = '1;
	localparam int REC_MAX = 32;

	typedef enum logic [2:0] {
		CMD_ADD  = 3'd0,
		CMD_ENQ  = 3'd1,
		CMD_CUR  = 3'd2,
		CMD_PLAY = 3'd3,
		CMD_TOT  = 3'd4,
		CMD_REC  = 3'd5,
		CMD_DEL  = 3'd6,
		CMD_BAD  = 3'd7
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ERR   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_NONE  = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		PASS_SCAN = 2'd0,
		PASS_QRM  = 2'd1,
		PASS_RRM  = 2'd2,
		PASS_SHR  = 2'd3
	} pass_e;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_SCAN_W,
		S_ENQ_A,
		S_ENQ_B,
		S_DEL_A,
		S_DEL_B,
		S_DEL_QW,
		S_DEL_RW,
		S_HEAD_A,
		S_HEAD_B,
		S_HEAD_C,
		S_HEAD_D,
		S_PLAY_QW,
		S_PLAY_RW,
		S_PLAY_SW,
		S_REC_CHK,
		S_REC_A,
		S_REC_B,
		S_REC_C,
		S_REC_D,
		S_REC_E,
		S_FIN
	} ctl_state_e;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] song_key;
		logic [15:0] song_length;
		logic [5:0]  recent_count;
	} in_item_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [31:0]     result_key;
		logic [QT_W-1:0] queued_time;
		logic            last_item;
	} out_item_t;

	typedef struct packed {
		logic    ld_in;
		logic    pass_start;
		pass_e   pass_kind;
		logic    ld_h_slot;
		logic    ld_h_q;
		logic    ld_h_r;
		logic    ld_kl;
		logic    add_commit;
		logic    enq_commit;
		logic    time_sub;
		logic    play_commit;
		logic    del_commit;
		logic    rec_init;
		logic    rec_next;
		logic    emit;
		status_e emit_st;
		logic    emit_key;
		logic    emit_last;
	} dp_cmd_t;

	typedef struct packed {
		cmd_e cmd;
		logic found;
		logic free_ok;
		logic queued_hit;
		logic q_empty;
		logic pass_done;
		logic out_free;
		logic rec_zero;
		logic rec_last;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/playlist_queue_recent_table.sv =====
`default_nettype none
// Add, enqueue and delete scan the catalog;
// delete adds a pass over the queue and one over the recent list.
// Play walks the queue and the recent list and then shifts the recent list.
// Recent emits one result item per listed key; other commands emit a single item.
// One command at a time; a finished result waits in an output register.
// Reset clears the flags, fills and sum at once; no clearing pass is run.
// ----------------------------------------------------------------------------
// playlist_queue_recent_table: song catalog with FIFO play queue and
// most-recent-first history
// Controller sequences each command over the catalog/list datapath.
// ----------------------------------------------------------------------------
module playlist_queue_recent_table import pqrt_pkg::*; #(
	parameter int CATALOG_ENTRIES = CATALOG_ENTRIES_DEF,
	parameter int KEY_WIDTH       = KEY_WIDTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire in_item_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output out_item_t     rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	pqrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pqrt_dp #(
		.CATALOG_ENTRIES (CATALOG_ENTRIES),
		.KEY_WIDTH       (KEY_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_ready (rsp_ready)
	);

endmodule
`default_nettype wire

// ===== hdl/pqrt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pqrt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pqrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/pqrt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pqrt_ctrl: command sequencer
// Steps each command through its key scan, list passes, reads and the
// transfers of its result items.
// ----------------------------------------------------------------------------
module pqrt_ctrl import pqrt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	ctl_state_e state_q, state_d;
	status_e    fin_st_q, fin_st_d;
	logic       fin_key_q, fin_key_d;

	// state and final result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fin_st_q  <= ST_OK;
			fin_key_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			fin_st_q  <= fin_st_d;
			fin_key_q <= fin_key_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d   = state_q;
		fin_st_d  = fin_st_q;
		fin_key_d = fin_key_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				fin_key_d = 1'b0;
				unique case (sts.cmd) inside
					CMD_ADD, CMD_ENQ, CMD_DEL: begin
						cmd.pass_start = 1'b1;
						cmd.pass_kind  = PASS_SCAN;
						state_d        = S_SCAN_W;
					end
					CMD_CUR: begin
						if (sts.q_empty) begin
							fin_st_d = ST_ERR;
							state_d  = S_FIN;
						end else begin
							state_d = S_HEAD_A;
						end
					end
					CMD_PLAY: begin
						if (sts.q_empty) begin
							fin_st_d = ST_EMPTY;
							state_d  = S_FIN;
						end else begin
							state_d = S_HEAD_A;
						end
					end
					CMD_TOT: begin
						fin_st_d = ST_OK;
						state_d  = S_FIN;
					end
					CMD_REC: begin
						cmd.rec_init = 1'b1;
						state_d      = S_REC_CHK;
					end
					default: begin
						fin_st_d = ST_ERR;
						state_d  = S_FIN;
					end
				endcase
			end
			S_SCAN_W: begin
				if (sts.pass_done) begin
					unique case (sts.cmd)
						CMD_ADD: begin
							if (sts.found || !sts.free_ok) begin
								fin_st_d = ST_ERR;
							end else begin
								cmd.add_commit = 1'b1;
								fin_st_d       = ST_OK;
							end
							state_d = S_FIN;
						end
						CMD_ENQ: begin
							if (!sts.found) begin
								fin_st_d = ST_ERR;
								state_d  = S_FIN;
							end else begin
								cmd.ld_h_slot = 1'b1;
								state_d       = S_ENQ_A;
							end
						end
						default: begin
							if (!sts.found) begin
								fin_st_d = ST_OK;
								state_d  = S_FIN;
							end else begin
								cmd.ld_h_slot = 1'b1;
								state_d       = S_DEL_A;
							end
						end
					endcase
				end
			end
			S_ENQ_A: state_d = S_ENQ_B;
			S_ENQ_B: begin
				cmd.enq_commit = !sts.queued_hit;
				fin_st_d       = ST_OK;
				state_d        = S_FIN;
			end
			S_DEL_A: state_d = S_DEL_B;
			S_DEL_B: begin
				cmd.time_sub   = sts.queued_hit;
				cmd.pass_start = 1'b1;
				cmd.pass_kind  = PASS_QRM;
				state_d        = S_DEL_QW;
			end
			S_DEL_QW: begin
				if (sts.pass_done) begin
					cmd.pass_start = 1'b1;
					cmd.pass_kind  = PASS_RRM;
					state_d        = S_DEL_RW;
				end
			end
			S_DEL_RW: begin
				if (sts.pass_done) begin
					cmd.del_commit = 1'b1;
					fin_st_d       = ST_OK;
					state_d        = S_FIN;
				end
			end
			S_HEAD_A: state_d = S_HEAD_B;
			S_HEAD_B: begin
				cmd.ld_h_q = 1'b1;
				state_d    = S_HEAD_C;
			end
			S_HEAD_C: state_d = S_HEAD_D;
			S_HEAD_D: begin
				cmd.ld_kl = 1'b1;
				fin_st_d  = ST_OK;
				fin_key_d = 1'b1;
				if (sts.cmd == CMD_PLAY) begin
					cmd.time_sub   = 1'b1;
					cmd.pass_start = 1'b1;
					cmd.pass_kind  = PASS_QRM;
					state_d        = S_PLAY_QW;
				end else begin
					state_d = S_FIN;
				end
			end
			S_PLAY_QW: begin
				if (sts.pass_done) begin
					cmd.pass_start = 1'b1;
					cmd.pass_kind  = PASS_RRM;
					state_d        = S_PLAY_RW;
				end
			end
			S_PLAY_RW: begin
				if (sts.pass_done) begin
					cmd.pass_start = 1'b1;
					cmd.pass_kind  = PASS_SHR;
					state_d        = S_PLAY_SW;
				end
			end
			S_PLAY_SW: begin
				if (sts.pass_done) begin
					cmd.play_commit = 1'b1;
					state_d         = S_FIN;
				end
			end
			S_REC_CHK: begin
				if (sts.rec_zero) begin
					fin_st_d = ST_NONE;
					state_d  = S_FIN;
				end else begin
					state_d = S_REC_A;
				end
			end
			S_REC_A: state_d = S_REC_B;
			S_REC_B: begin
				cmd.ld_h_r = 1'b1;
				state_d    = S_REC_C;
			end
			S_REC_C: state_d = S_REC_D;
			S_REC_D: begin
				cmd.ld_kl = 1'b1;
				state_d   = S_REC_E;
			end
			S_REC_E: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_st   = ST_OK;
					cmd.emit_key  = 1'b1;
					cmd.emit_last = sts.rec_last;
					if (sts.rec_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.rec_next = 1'b1;
						state_d      = S_REC_A;
					end
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_st   = fin_st_q;
					cmd.emit_key  = fin_key_q;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/pqrt_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pqrt_dp: catalog, queue and recent-list datapath
// Holds the catalog memories, the queue and recent slot lists, entry flags,
// the queued time sum, the scan/pass engine and the result register.
// ----------------------------------------------------------------------------
module pqrt_dp import pqrt_pkg::*; #(
	parameter int CATALOG_ENTRIES = CATALOG_ENTRIES_DEF,
	parameter int KEY_WIDTH       = KEY_WIDTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t req,
	input  wire dp_cmd_t  cmd,
	output dp_sts_t       sts,
	output logic          rsp_valid,
	output out_item_t     rsp,
	input  wire logic     rsp_ready
);

	localparam int N   = CATALOG_ENTRIES;
	localparam int SW  = $clog2(N);
	localparam int CW  = $clog2(N + 1);
	localparam int TW  = $clog2(N * 65535 + 1);
	localparam int TSW = (TW > QT_W) ? TW : QT_W;

	// captured command
	cmd_e                 cmd_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [15:0]          len_q;
	logic [5:0]           want_q;

	// scan results and working slot
	logic          found_q, free_ok_q;
	logic [SW-1:0] slot_q, free_q, h_q;

	// list fills, flags, time sum
	logic [CW-1:0]  qfill_q, rfill_q;
	logic [N-1:0]   valid_q, queued_q, played_q;
	logic [TSW-1:0] tsum_q;

	// pass engine
	pass_e         pass_q;
	logic [CW-1:0] cnt_q, rem_q;
	logic          vld_s1, rm_found_q;
	logic [SW-1:0] idx_s1;
	logic          issue;

	logic [KEY_WIDTH-1:0] kdat_q;
	logic [5:0]           rec_n_q, rec_k_q;
	logic [6:0]           rec_min, rec_cap;

	// memory ports
	logic                 key_we, len_we, q_we, r_we;
	logic [SW-1:0]        key_raddr, q_raddr, q_waddr, r_raddr, r_waddr;
	logic [KEY_WIDTH-1:0] key_rdata;
	logic [15:0]          len_rdata;
	logic [SW-1:0]        q_wdata, q_rdata, r_wdata, r_rdata;

	assign issue = (rem_q != '0);

	pqrt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(N)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(free_q), .wdata(key_q),
		.raddr(key_raddr), .rdata(key_rdata)
	);

	pqrt_ram #(.WIDTH(16), .DEPTH(N)) u_len_ram (
		.clk(clk), .we(len_we), .waddr(free_q), .wdata(len_q),
		.raddr(h_q), .rdata(len_rdata)
	);

	pqrt_ram #(.WIDTH(SW), .DEPTH(N)) u_queue_ram (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	pqrt_ram #(.WIDTH(SW), .DEPTH(N)) u_recent_ram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	// memory address and write selection
	always_comb begin
		key_we    = cmd.add_commit;
		len_we    = cmd.add_commit;
		key_raddr = (issue && pass_q == PASS_SCAN) ? cnt_q[SW-1:0] : h_q;
		q_raddr   = (issue && pass_q == PASS_QRM) ? cnt_q[SW-1:0] : '0;
		r_raddr   = (issue && (pass_q == PASS_RRM || pass_q == PASS_SHR)) ?
			cnt_q[SW-1:0] : SW'(rec_k_q);

		q_we    = cmd.enq_commit || (vld_s1 && pass_q == PASS_QRM && rm_found_q);
		q_waddr = cmd.enq_commit ? SW'(qfill_q) : SW'(idx_s1 - SW'(1));
		q_wdata = cmd.enq_commit ? h_q : q_rdata;

		r_we = cmd.play_commit || (vld_s1 && pass_q == PASS_SHR) ||
			(vld_s1 && pass_q == PASS_RRM && rm_found_q);
		if (cmd.play_commit) begin
			r_waddr = '0;
		end else if (pass_q == PASS_SHR) begin
			r_waddr = SW'(idx_s1 + SW'(1));
		end else begin
			r_waddr = SW'(idx_s1 - SW'(1));
		end
		r_wdata = cmd.play_commit ? h_q : r_rdata;
	end

	// recent count: min(request, fill, cap)
	always_comb begin
		rec_min = (7'(want_q) < 7'(rfill_q)) ? 7'(want_q) : 7'(rfill_q);
		rec_cap = (rec_min > 7'(REC_MAX)) ? 7'(REC_MAX) : rec_min;
	end

	// control state: fills, flags, sum, pass engine, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qfill_q    <= '0;
			rfill_q    <= '0;
			valid_q    <= '0;
			queued_q   <= '0;
			played_q   <= '0;
			tsum_q     <= '0;
			pass_q     <= PASS_SCAN;
			rem_q      <= '0;
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			rm_found_q <= 1'b0;
			found_q    <= 1'b0;
			free_ok_q  <= 1'b0;
			rsp_valid  <= 1'b0;
		end else begin
			vld_s1 <= issue && !cmd.pass_start;

			// start or advance a pass
			if (cmd.pass_start) begin
				pass_q     <= cmd.pass_kind;
				rm_found_q <= 1'b0;
				cnt_q      <= '0;
				case (cmd.pass_kind)
					PASS_SCAN: begin
						rem_q     <= CW'(N);
						found_q   <= 1'b0;
						free_ok_q <= 1'b0;
					end
					PASS_QRM: rem_q <= qfill_q;
					PASS_RRM: rem_q <= rfill_q;
					default: begin
						rem_q <= rfill_q;
						cnt_q <= rfill_q - CW'(1);
					end
				endcase
			end else if (issue) begin
				rem_q <= rem_q - CW'(1);
				cnt_q <= (pass_q == PASS_SHR) ? cnt_q - CW'(1) : cnt_q + CW'(1);
				if (pass_q == PASS_SCAN && !valid_q[cnt_q[SW-1:0]] && !free_ok_q) begin
					free_ok_q <= 1'b1;
				end
			end

			// compare the word read in the previous cycle
			if (vld_s1) begin
				case (pass_q)
					PASS_SCAN: begin
						if (valid_q[idx_s1] && key_rdata == key_q) begin
							found_q <= 1'b1;
						end
					end
					PASS_QRM: begin
						if (q_rdata == h_q) begin
							rm_found_q <= 1'b1;
							qfill_q    <= qfill_q - CW'(1);
						end
					end
					PASS_RRM: begin
						if (r_rdata == h_q) begin
							rm_found_q <= 1'b1;
							rfill_q    <= rfill_q - CW'(1);
						end
					end
					default: ;
				endcase
			end

			// commits
			if (cmd.add_commit) begin
				valid_q[free_q]  <= 1'b1;
				queued_q[free_q] <= 1'b0;
				played_q[free_q] <= 1'b0;
			end
			if (cmd.enq_commit) begin
				queued_q[h_q] <= 1'b1;
				qfill_q       <= qfill_q + CW'(1);
				tsum_q        <= tsum_q + TSW'(len_rdata);
			end
			if (cmd.time_sub) begin
				tsum_q <= tsum_q - TSW'(len_rdata);
			end
			if (cmd.play_commit) begin
				played_q[h_q] <= 1'b1;
				queued_q[h_q] <= 1'b0;
				rfill_q       <= rfill_q + CW'(1);
			end
			if (cmd.del_commit) begin
				valid_q[h_q]  <= 1'b0;
				queued_q[h_q] <= 1'b0;
				played_q[h_q] <= 1'b0;
			end

			// result register: load on emit, drop on transfer
			if (cmd.emit) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[SW-1:0];
		if (cmd.ld_in) begin
			cmd_q  <= cmd_e'(req.command);
			key_q  <= KEY_WIDTH'(req.song_key);
			len_q  <= req.song_length;
			want_q <= req.recent_count;
		end
		if (issue && !cmd.pass_start && pass_q == PASS_SCAN &&
			!valid_q[cnt_q[SW-1:0]] && !free_ok_q) begin
			free_q <= cnt_q[SW-1:0];
		end
		if (vld_s1 && pass_q == PASS_SCAN && valid_q[idx_s1] && key_rdata == key_q) begin
			slot_q <= idx_s1;
		end
		if (cmd.ld_h_slot) begin
			h_q <= slot_q;
		end else if (cmd.ld_h_q) begin
			h_q <= q_rdata;
		end else if (cmd.ld_h_r) begin
			h_q <= r_rdata;
		end
		if (cmd.ld_kl) begin
			kdat_q <= key_rdata;
		end
		if (cmd.rec_init) begin
			rec_n_q <= 6'(rec_cap);
			rec_k_q <= '0;
		end else if (cmd.rec_next) begin
			rec_k_q <= rec_k_q + 6'd1;
		end
		if (cmd.emit) begin
			rsp.status      <= cmd.emit_st;
			rsp.result_key  <= cmd.emit_key ? 32'(kdat_q) : 32'd0;
			rsp.queued_time <= (tsum_q > TSW'(QT_MAX)) ? QT_MAX : QT_W'(tsum_q);
			rsp.last_item   <= cmd.emit_last;
		end
	end

	// status to the controller
	always_comb begin
		sts.cmd        = cmd_q;
		sts.found      = found_q;
		sts.free_ok    = free_ok_q;
		sts.queued_hit = queued_q[h_q];
		sts.q_empty    = (qfill_q == '0);
		sts.pass_done  = !issue && !vld_s1;
		sts.out_free   = !rsp_valid || rsp_ready;
		sts.rec_zero   = (rec_n_q == '0);
		sts.rec_last   = (7'(rec_k_q) + 7'd1 == 7'(rec_n_q));
	end

	// queue and recent fills track their membership flags once a command settles
	a_qfill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> ($countones(queued_q) == int'(qfill_q)))
		else $error("queue fill disagrees with queued flags");
	a_rfill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> ($countones(played_q) == int'(rfill_q)))
		else $error("recent fill disagrees with played flags");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		((queued_q | played_q) & ~valid_q) == '0)
		else $error("list flag set on an empty catalog entry");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!rsp_valid || rsp_ready))
		else $error("result overwritten before transfer");

endmodule
`default_nettype wire
